// ===== design/fme_pkg.sv =====
`default_nettype none

package fme_pkg;

	// Configuration register indexes.
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_KIND  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_ONE   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_TWO   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_THREE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK_FOUR  = 3'd4;

	localparam int SHAPE_BITS = 2;

	typedef enum logic [SHAPE_BITS-1:0] {
		SHAPE_FALLING   = 2'd0,
		SHAPE_RISING    = 2'd1,
		SHAPE_TRIANGLE  = 2'd2,
		SHAPE_TRAPEZOID = 2'd3
	} shape_t;

	// How the final degree is formed: constant zero, constant one, or ramp quotient.
	localparam int DEG_SEL_BITS = 2;

	typedef enum logic [DEG_SEL_BITS-1:0] {
		SEL_ZERO = 2'd0,
		SEL_FULL = 2'd1,
		SEL_RAMP = 2'd2
	} deg_sel_t;

endpackage

`default_nettype wire

// ===== design/fme_ramp_div.sv =====
`default_nettype none

module fme_ramp_div #(
	parameter int POINT_BITS       = 16,
	parameter int DEGREE_FRAC_BITS = 15,
	parameter int SIDE_BITS        = 19
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [POINT_BITS-1:0]       in_num,
	input  wire logic [POINT_BITS-1:0]       in_den,
	input  wire logic [SIDE_BITS-1:0]        in_side,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [DEGREE_FRAC_BITS-1:0]      out_quo,
	output logic [SIDE_BITS-1:0]             out_side
);

	localparam int PB = POINT_BITS;
	localparam int NS = DEGREE_FRAC_BITS;

	// One restoring step per stage; the numerator is always below the divisor.
	logic                 vld_s  [NS];
	logic [PB-1:0]        rem_s  [NS];
	logic [PB-1:0]        dvs_s  [NS];
	logic [NS-1:0]        quo_s  [NS];
	logic [SIDE_BITS-1:0] side_s [NS];
	logic [NS:0]          adv;

	assign adv[NS]  = out_ready;
	assign in_ready = adv[0];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic                 v_in;
		logic [PB-1:0]        r_in;
		logic [PB-1:0]        d_in;
		logic [NS-1:0]        q_in;
		logic [SIDE_BITS-1:0] sd_in;
		logic [PB:0]          trial;
		logic                 fits;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = in_num;
			assign d_in  = in_den;
			assign q_in  = '0;
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign r_in  = rem_s[k-1];
			assign d_in  = dvs_s[k-1];
			assign q_in  = quo_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign adv[k] = !vld_s[k] || adv[k+1];
		assign trial  = {r_in, 1'b0} - {1'b0, d_in};
		assign fits   = !trial[PB];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= fits ? trial[PB-1:0] : {r_in[PB-2:0], 1'b0};
				dvs_s[k]  <= d_in;
				quo_s[k]  <= {q_in[NS-2:0], fits};
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_quo   = quo_s[NS-1];
	assign out_side  = side_s[NS-1];

	// The partial remainder must stay below the divisor; the first and last stages are checked.
	a_rem_first: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> rem_s[0] < dvs_s[0])
		else $error("first-stage remainder not below divisor");

	a_rem_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem_s[NS-1] < dvs_s[NS-1])
		else $error("last-stage remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_quo))
		else $error("stalled quotient changed");

endmodule

`default_nettype wire

// ===== design/fuzzy_membership_eval_top.sv =====
`default_nettype none

// Channel  Dir  Fields (lowest bit up)                       Handshake
// s_       in   tdata: sample_point                          s_tvalid/s_tready
// m_       out  tdata: degree, crisp_value; tuser: defined   m_tvalid/m_tready
// cfg_     in   cfg_index selects register, cfg_data value   cfg_wr_en, no wait
//
// One sample per cycle sustained while m_tready is high: one stage selects the ramp,
// one classifies it, then one restoring divider step per stage.
// Reset clears the stage valid bits and the registers (shape trapezoid, breaks 0).
// A stalled output holds its transaction; each stage loads when it is empty or its
// successor frees up, so empty slots close up and nothing is lost or repeated.

module fuzzy_membership_eval_top #(
	parameter int POINT_BITS       = 16,
	parameter int DEGREE_FRAC_BITS = 15
) (
	input  wire logic                                         clk,
	input  wire logic                                         arst_n,
	input  wire logic                                         s_tvalid,
	output logic                                              s_tready,
	input  wire logic [((POINT_BITS+7)/8)*8-1:0]              s_tdata,  // sample_point
	output logic                                              m_tvalid,
	input  wire logic                                         m_tready,
	// degree, crisp_value
	output logic [((DEGREE_FRAC_BITS+1+POINT_BITS+7)/8)*8-1:0] m_tdata,
	output logic [0:0]                                        m_tuser,  // crisp_defined
	input  wire logic                                         cfg_wr_en,
	input  wire logic [fme_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
	input  wire logic [POINT_BITS-1:0]                        cfg_data
);

	import fme_pkg::*;

	localparam int PB     = POINT_BITS;
	localparam int DEG_W  = DEGREE_FRAC_BITS + 1;
	localparam int OUT_W  = ((DEG_W + PB + 7) / 8) * 8;
	localparam int SIDE_W = DEG_SEL_BITS + 1 + PB;
	localparam logic [DEG_W-1:0] DEG_ONE = DEG_W'(1) << DEGREE_FRAC_BITS;

	// Configuration registers.
	shape_t                shape_q;
	logic signed [PB-1:0]  brk_one_q;
	logic signed [PB-1:0]  brk_two_q;
	logic signed [PB-1:0]  brk_three_q;
	logic signed [PB-1:0]  brk_four_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q     <= SHAPE_TRAPEZOID;
			brk_one_q   <= '0;
			brk_two_q   <= '0;
			brk_three_q <= '0;
			brk_four_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SHAPE_KIND:  shape_q     <= shape_t'(cfg_data[SHAPE_BITS-1:0]);
				REG_BREAK_ONE:   brk_one_q   <= cfg_data;
				REG_BREAK_TWO:   brk_two_q   <= cfg_data;
				REG_BREAK_THREE: brk_three_q <= cfg_data;
				REG_BREAK_FOUR:  brk_four_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: pick the branch and form the ramp operands.
	logic signed [PB-1:0] pt;
	logic signed [PB:0]   ext_p, ext_b1, ext_b2, ext_b3, ext_b4;
	logic signed [PB:0]   d_pb1, d_b2b1, d_b4p, d_b4b3, d_b4b2, mid_sum;
	logic signed [PB:0]   num_c, den_c;
	deg_sel_t             sel_c;
	logic signed [PB-1:0] crisp_c;
	logic                 def_c;

	assign pt      = s_tdata[PB-1:0];
	assign ext_p   = {pt[PB-1], pt};
	assign ext_b1  = {brk_one_q[PB-1], brk_one_q};
	assign ext_b2  = {brk_two_q[PB-1], brk_two_q};
	assign ext_b3  = {brk_three_q[PB-1], brk_three_q};
	assign ext_b4  = {brk_four_q[PB-1], brk_four_q};
	assign d_pb1   = ext_p - ext_b1;
	assign d_b2b1  = ext_b2 - ext_b1;
	assign d_b4p   = ext_b4 - ext_p;
	assign d_b4b3  = ext_b4 - ext_b3;
	assign d_b4b2  = ext_b4 - ext_b2;
	assign mid_sum = ext_b2 + ext_b3;

	always_comb begin
		sel_c   = SEL_ZERO;
		num_c   = d_pb1;
		den_c   = d_b2b1;
		crisp_c = '0;
		def_c   = 1'b0;
		unique case (shape_q)
			SHAPE_FALLING: begin
				num_c = d_b4p;
				den_c = d_b4b3;
				priority if (pt <= brk_three_q) sel_c = SEL_FULL;
				else if (pt < brk_four_q)       sel_c = SEL_RAMP;
				else                            sel_c = SEL_ZERO;
			end
			SHAPE_RISING: begin
				priority if (pt <= brk_one_q) sel_c = SEL_ZERO;
				else if (pt < brk_two_q)      sel_c = SEL_RAMP;
				else                          sel_c = SEL_FULL;
			end
			SHAPE_TRIANGLE: begin
				crisp_c = brk_two_q;
				def_c   = 1'b1;
				priority if (pt <= brk_one_q) begin
					sel_c = SEL_ZERO;
				end else if (pt <= brk_two_q) begin
					sel_c = SEL_RAMP;
				end else if (pt < brk_four_q) begin
					sel_c = SEL_RAMP;
					num_c = d_b4p;
					den_c = d_b4b2;
				end else begin
					sel_c = SEL_ZERO;
				end
			end
			SHAPE_TRAPEZOID: begin
				// Arithmetic shift floors the plateau midpoint.
				crisp_c = mid_sum[PB:1];
				def_c   = 1'b1;
				priority if (pt <= brk_one_q) begin
					sel_c = SEL_ZERO;
				end else if (pt < brk_two_q) begin
					sel_c = SEL_RAMP;
				end else if (pt <= brk_three_q) begin
					sel_c = SEL_FULL;
				end else if (pt < brk_four_q) begin
					sel_c = SEL_RAMP;
					num_c = d_b4p;
					den_c = d_b4b3;
				end else begin
					sel_c = SEL_ZERO;
				end
			end
			default: ;
		endcase
	end

	logic                 vld_s1, vld_s2;
	logic                 ld1, ld2, div_in_ready;
	logic signed [PB:0]   num_s1, den_s1;
	deg_sel_t             sel_s1, sel_s2;
	logic signed [PB-1:0] crisp_s1, crisp_s2;
	logic                 def_s1, def_s2;
	logic [PB-1:0]        num_s2, den_s2;

	assign ld1      = !vld_s1 || ld2;
	assign ld2      = !vld_s2 || div_in_ready;
	assign s_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ld1) vld_s1 <= s_tvalid;
			if (ld2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			num_s1   <= num_c;
			den_s1   <= den_c;
			sel_s1   <= sel_c;
			crisp_s1 <= crisp_c;
			def_s1   <= def_c;
		end
	end

	// Stage 2: settle the ramp's special cases; the divider only sees num < den.
	deg_sel_t      sel2_c;
	logic [PB-1:0] num2_c, den2_c;

	always_comb begin
		sel2_c = sel_s1;
		num2_c = '0;
		den2_c = PB'(1);
		if (sel_s1 == SEL_RAMP) begin
			priority if (den_s1 <= 0 || num_s1 < 0) begin
				sel2_c = SEL_ZERO;
			end else if (num_s1 >= den_s1) begin
				sel2_c = SEL_FULL;
			end else begin
				num2_c = num_s1[PB-1:0];
				den2_c = den_s1[PB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			num_s2   <= num2_c;
			den_s2   <= den2_c;
			sel_s2   <= sel2_c;
			crisp_s2 <= crisp_s1;
			def_s2   <= def_s1;
		end
	end

	logic                        div_out_valid;
	logic [DEGREE_FRAC_BITS-1:0] div_quo;
	logic [SIDE_W-1:0]           div_side;
	deg_sel_t                    out_sel;
	logic [PB-1:0]               out_crisp;
	logic [DEG_W-1:0]            out_deg;

	fme_ramp_div #(
		.POINT_BITS       (PB),
		.DEGREE_FRAC_BITS (DEGREE_FRAC_BITS),
		.SIDE_BITS        (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_in_ready),
		.in_num    (num_s2),
		.in_den    (den_s2),
		.in_side   ({sel_s2, def_s2, crisp_s2}),
		.out_valid (div_out_valid),
		.out_ready (m_tready),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	assign out_sel   = deg_sel_t'(div_side[SIDE_W-1 -: DEG_SEL_BITS]);
	assign out_crisp = div_side[PB-1:0];

	always_comb begin
		unique case (out_sel)
			SEL_FULL: out_deg = DEG_ONE;
			SEL_RAMP: out_deg = {1'b0, div_quo};
			default:  out_deg = '0;
		endcase
	end

	assign m_tvalid   = div_out_valid;
	assign m_tdata    = OUT_W'({out_crisp, out_deg});
	assign m_tuser[0] = div_side[PB];

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DEG_W-1:0] <= DEG_ONE)
		else $error("degree above one");

	a_crisp_undef: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[DEG_W +: PB] == '0)
		else $error("undefined crisp value not zero");

	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output slot empty");

	a_ramp_sel: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && sel_s2 == SEL_RAMP |-> num_s2 < den_s2)
		else $error("ramp operands reach divider unsettled");

endmodule

`default_nettype wire
